[src/ubxp_pkg.sv]
// shared types and constants for the ubx frame parser
// no dependencies; used by every module under src
package ubxp_pkg;

  // result kinds as seen on the output tuser
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_ACCEPT   = 3'd1;
  localparam logic [2:0] KIND_IGNORE   = 3'd2;
  localparam logic [2:0] KIND_CKERR    = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW = 3'd4;

  // event codes passed from the front parser to the back end
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_GOOD  = 2'd1;
  localparam logic [1:0] OP_CKERR = 2'd2;
  localparam logic [1:0] OP_OVFL  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] REG_FILTER_0    = 3'd2;
  localparam logic [2:0] REG_FILTER_1    = 3'd3;
  localparam logic [2:0] REG_FILTER_2    = 3'd4;
  localparam logic [2:0] REG_FILTER_3    = 3'd5;

  localparam int NUM_FILTERS = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

  // one filter entry, msb first
  typedef struct packed {
    logic        valid;
    logic [15:0] length;
    logic        len_check;
    logic        any_id;
    logic [7:0]  id;
    logic [7:0]  cls;
  } ubxp_filter_t;

  // one parser event in the queue
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] length;
  } ubxp_event_t;

endpackage

[src/ubxp_front.sv]
// front parser: sync hunt, header capture, fletcher sum, event generation
// depends on ubxp_pkg
module ubxp_front #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic                 q_full,
  output logic                 byte_ready,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           sync_first,
  input  logic [7:0]           sync_second,
  output logic                 push,
  output ubxp_pkg::ubxp_event_t ev
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        take;
  logic        emit;
  logic [1:0]  op;
  logic [7:0]  acc_a, acc_b;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;

  // fletcher step, restarted on the class byte
  assign acc_a    = ((phase_r == PH_CLASS) ? 8'd0 : sum_a_r) + rx_byte;
  assign acc_b    = ((phase_r == PH_CLASS) ? 8'd0 : sum_b_r) + acc_a;
  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = {rx_byte, len_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    cls_nxt   = cls_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    op        = ubxp_pkg::OP_DATA;
    unique case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == sync_first) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == sync_second) phase_nxt = PH_CLASS;
        else if (rx_byte == sync_first) phase_nxt = PH_SYNC2;
        else phase_nxt = PH_SYNC1;
      end
      PH_CLASS: begin
        cls_nxt   = rx_byte;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = PH_LEN1;
      end
      PH_LEN1: begin
        len_nxt   = {8'd0, rx_byte};
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        phase_nxt = PH_LEN2;
      end
      PH_LEN2: begin
        len_nxt   = len_full;
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        cnt_nxt   = 16'd0;
        if (len_full > MAX_LEN) begin
          phase_nxt = PH_SYNC1;
          emit      = 1'b1;
          op        = ubxp_pkg::OP_OVFL;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CKA;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) phase_nxt = PH_CKA;
        emit = 1'b1;
        op   = ubxp_pkg::OP_DATA;
      end
      PH_CKA: begin
        if (rx_byte != sum_a_r) begin
          phase_nxt = PH_SYNC1;
          emit      = 1'b1;
          op        = ubxp_pkg::OP_CKERR;
        end else begin
          phase_nxt = PH_CKB;
        end
      end
      PH_CKB: begin
        phase_nxt = PH_SYNC1;
        emit      = 1'b1;
        op        = (rx_byte != sum_b_r) ? ubxp_pkg::OP_CKERR : ubxp_pkg::OP_GOOD;
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
  end

  assign push      = take && emit;
  assign ev.op     = op;
  assign ev.data   = (op == ubxp_pkg::OP_DATA) ? rx_byte : 8'd0;
  assign ev.cls    = cls_nxt;
  assign ev.id     = id_nxt;
  assign ev.length = len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      cls_r   <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      cls_r   <= cls_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/ubxp_queue.sv]
// four-entry event queue between the front parser and the back end
// depends on ubxp_pkg
module ubxp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ubxp_pkg::ubxp_event_t push_ev,
  input  logic                  pop,
  output ubxp_pkg::ubxp_event_t head_ev,
  output logic                  not_empty,
  output logic                  full
);

  ubxp_pkg::ubxp_event_t                 slot_r [ubxp_pkg::QDEPTH];
  logic [ubxp_pkg::QPTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [ubxp_pkg::QPTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [ubxp_pkg::QCNT_W-1:0]           cnt_r, cnt_nxt;
  logic                                  do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == ubxp_pkg::QCNT_W'(ubxp_pkg::QDEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_ev   = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + ubxp_pkg::QPTR_W'(do_push);
  assign rd_ptr_nxt = rd_ptr_r + ubxp_pkg::QPTR_W'(do_pop);
  assign cnt_nxt    = cnt_r + ubxp_pkg::QCNT_W'(do_push) - ubxp_pkg::QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/ubxp_back.sv]
// back end: filter match on finished frames and the output register
// depends on ubxp_pkg
module ubxp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  input  ubxp_pkg::ubxp_event_t ev,
  output logic                  ev_pop,
  input  ubxp_pkg::ubxp_filter_t filt [ubxp_pkg::NUM_FILTERS],
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [2:0]            res_kind,
  output logic [7:0]            res_data,
  output logic [7:0]            res_class,
  output logic [7:0]            res_id,
  output logic [15:0]           res_length,
  output logic [1:0]            res_index
);

  logic                             valid_r;
  logic [2:0]                       kind_r, kind_nxt;
  logic [7:0]                       data_r, class_r, id_r;
  logic [15:0]                      length_r;
  logic [1:0]                       index_r, index_nxt;
  logic [ubxp_pkg::NUM_FILTERS-1:0] exact, wild;
  logic                             exact_any, wild_any;
  logic [1:0]                       exact_idx, wild_idx, pick;
  logic                             len_ok;

  // parallel compare of all entries against the frame header
  always_comb begin
    for (int i = 0; i < ubxp_pkg::NUM_FILTERS; i++) begin
      exact[i] = filt[i].valid && (filt[i].cls == ev.cls) && !filt[i].any_id &&
                 (filt[i].id == ev.id);
      wild[i]  = filt[i].valid && (filt[i].cls == ev.cls) && filt[i].any_id;
    end
  end

  assign exact_any = |exact;
  assign wild_any  = |wild;

  always_comb begin
    priority casez (exact)
      4'b???1: exact_idx = 2'd0;
      4'b??10: exact_idx = 2'd1;
      4'b?100: exact_idx = 2'd2;
      default: exact_idx = 2'd3;
    endcase
    priority casez (wild)
      4'b???1: wild_idx = 2'd0;
      4'b??10: wild_idx = 2'd1;
      4'b?100: wild_idx = 2'd2;
      default: wild_idx = 2'd3;
    endcase
  end

  assign pick   = exact_any ? exact_idx : wild_idx;
  assign len_ok = !filt[pick].len_check || (filt[pick].length == ev.length);

  always_comb begin
    index_nxt = 2'd0;
    unique case (ev.op)
      ubxp_pkg::OP_DATA:  kind_nxt = ubxp_pkg::KIND_DATA;
      ubxp_pkg::OP_CKERR: kind_nxt = ubxp_pkg::KIND_CKERR;
      ubxp_pkg::OP_OVFL:  kind_nxt = ubxp_pkg::KIND_OVERFLOW;
      ubxp_pkg::OP_GOOD: begin
        if ((exact_any || wild_any) && len_ok) begin
          kind_nxt  = ubxp_pkg::KIND_ACCEPT;
          index_nxt = pick;
        end else begin
          kind_nxt = ubxp_pkg::KIND_IGNORE;
        end
      end
      default: kind_nxt = ubxp_pkg::KIND_IGNORE;
    endcase
  end

  assign ev_pop = ev_valid && (!valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ev_pop) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      kind_r   <= kind_nxt;
      data_r   <= ev.data;
      class_r  <= ev.cls;
      id_r     <= ev.id;
      length_r <= ev.length;
      index_r  <= index_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_kind   = kind_r;
  assign res_data   = data_r;
  assign res_class  = class_r;
  assign res_id     = id_r;
  assign res_length = length_r;
  assign res_index  = index_r;

endmodule

[src/ubx_frame_parser.sv]
// top level of the ubx frame parser: configuration registers and wiring
// depends on ubxp_pkg, ubxp_front, ubxp_queue and ubxp_back

// Takes one received byte per beat and accepts a byte every cycle unless the
// event queue is full. Results leave through the event queue and then a
// registered output stage; in_tready drops only when the four-entry event queue
// is full, which happens only while the output side holds out_tready low. Each
// payload byte gives a data beat, and each frame ends in one outcome beat:
// accepted, ignored, checksum error, or overflow (length above MAX_PAYLOAD,
// reported right after the second length byte). Sync bytes and filter entries
// are written over the cfg port, which is always ready; write it only while the
// parser is idle.
module ubx_frame_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data_byte[7:0], msg_class[15:8], msg_id[23:16],
                                  // msg_length[39:24], match_index[41:40], zero[47:42]
  output logic [2:0]  out_tuser,  // kind[2:0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [34:0] cfg_data
);

  logic [7:0]             sync_first_r;
  logic [7:0]             sync_second_r;
  ubxp_pkg::ubxp_filter_t filt_r [ubxp_pkg::NUM_FILTERS];
  logic                   cfg_we;

  logic                   q_full, q_not_empty, q_push, q_pop;
  ubxp_pkg::ubxp_event_t  push_ev, head_ev;

  logic [2:0]             res_kind;
  logic [7:0]             res_data, res_class, res_id;
  logic [15:0]            res_length;
  logic [1:0]             res_index;

  // configuration registers, writes to unused indexes are dropped
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= ubxp_pkg::SYNC_FIRST_RST;
      sync_second_r <= ubxp_pkg::SYNC_SECOND_RST;
      for (int i = 0; i < ubxp_pkg::NUM_FILTERS; i++) filt_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ubxp_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_data[7:0];
        ubxp_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_data[7:0];
        ubxp_pkg::REG_FILTER_0:    filt_r[0]     <= cfg_data;
        ubxp_pkg::REG_FILTER_1:    filt_r[1]     <= cfg_data;
        ubxp_pkg::REG_FILTER_2:    filt_r[2]     <= cfg_data;
        ubxp_pkg::REG_FILTER_3:    filt_r[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: per-byte parse, pushes one event per result
  ubxp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .q_full     (q_full),
    .byte_ready (in_tready),
    .rx_byte    (in_tdata),
    .sync_first (sync_first_r),
    .sync_second(sync_second_r),
    .push       (q_push),
    .ev         (push_ev)
  );

  // decoupling queue
  ubxp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ev  (push_ev),
    .pop      (q_pop),
    .head_ev  (head_ev),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  // back: filter match and output register
  ubxp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_not_empty),
    .ev        (head_ev),
    .ev_pop    (q_pop),
    .filt      (filt_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (res_kind),
    .res_data  (res_data),
    .res_class (res_class),
    .res_id    (res_id),
    .res_length(res_length),
    .res_index (res_index)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {6'd0, res_index, res_length, res_id, res_class, res_data};

`ifndef NO_ASSERTIONS
  // outcome codes stay within the defined kinds
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= ubxp_pkg::KIND_OVERFLOW))
    else $error("result kind out of range");

  // data byte is only nonzero on payload beats
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ubxp_pkg::KIND_DATA)) |-> (out_tdata[7:0] == 8'd0))
    else $error("data byte set on a non-payload beat");

  // match index only carries meaning on accepted frames
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ubxp_pkg::KIND_ACCEPT)) |-> (out_tdata[41:40] == 2'd0))
    else $error("match index set on a non-accept beat");

  // input back-pressure only comes from a full queue behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && $past(out_tvalid)))
    else $error("input stalled without output back-pressure");
`endif

endmodule
